/* src/pack_record_scanner_assert.svh */
// assertion macros for the pack record scanner checker
// no dependencies; included by the checker file
`ifndef PACK_RECORD_SCANNER_ASSERT_SVH
`define PACK_RECORD_SCANNER_ASSERT_SVH

// condition implies consequence in the same cycle
`define PRS_ASSERT_IMPLY(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define PRS_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

/* src/prs_pkg.sv */
// shared types, codes and defaults for the pack record scanner
// no dependencies; imported by every scanner module
package prs_pkg;

	localparam int ADDR_WIDTH_DEF   = 20;
	localparam int HEADER_BYTES_DEF = 10;
	localparam int UNIT_BYTES_DEF   = 8192;

	localparam int START_W     = 20;
	localparam int LEN_W       = 16;
	localparam int FREE_W      = 21;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_WANTED_TYPE   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_RECORD = 1'd1;

	localparam logic [7:0] LONG_TYPE = 8'h80;
	localparam logic [7:0] END_MARK  = 8'hFF;

	localparam logic [2:0] EV_HEADER   = 3'd0;
	localparam logic [2:0] EV_DATA     = 3'd1;
	localparam logic [2:0] EV_END      = 3'd2;
	localparam logic [2:0] EV_ZERO_LEN = 3'd3;
	localparam logic [2:0] EV_BAD_END  = 3'd4;

	typedef struct packed {
		logic [7:0] pack_byte;
		logic       start_req;
	} prs_in_t;

	typedef struct packed {
		logic [2:0]         event_res;
		logic [START_W-1:0] record_start;
		logic [7:0]         rec_kind;
		logic [LEN_W-1:0]   record_length;
		logic               is_long;
		logic               type_matches;
		logic [LEN_W-1:0]   match_count;
		logic               is_target;
		logic [7:0]         data_byte;
		logic [START_W-1:0] free_addr;
		logic [FREE_W-1:0]  free_space;
	} prs_out_t;

endpackage

/* src/pack_record_scanner.sv */
// Pack record scanner: takes one pack byte per clock and reports records, data bytes and the
// end of pack. A byte passes an input register and the parser, and its result (if any) is
// registered in a result register that drives the output. One byte is taken every cycle while
// results are taken; a stalled result register holds the input side. There is no clearing
// pass after reset.
// depends on prs_pkg and the three prs modules.
module pack_record_scanner import prs_pkg::*; #(
	parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int UNIT_BYTES   = UNIT_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  prs_in_t                in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output prs_out_t               out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic     advance;
	logic     item_valid;
	prs_in_t  item;
	logic     res_valid;
	prs_out_t res;

	assign cfg_ready = 1'b1;

	prs_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	prs_scan_core #(
		.ADDR_WIDTH   (ADDR_WIDTH),
		.HEADER_BYTES (HEADER_BYTES),
		.UNIT_BYTES   (UNIT_BYTES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item       (item),
		.advance    (advance),
		.res_valid  (res_valid),
		.res        (res)
	);

	prs_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.res_valid  (res_valid),
		.res        (res),
		.advance    (advance),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

/* src/prs_in_stage.sv */
// input register of the pack record scanner
// depends on prs_pkg
module prs_in_stage import prs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  prs_in_t in_data,
	input  logic    advance,
	output logic    item_valid,
	output prs_in_t item
);

	logic    valid_s1;
	prs_in_t data_s1;
	logic    take;

	assign in_stall   = valid_s1 && !advance;
	assign take       = in_valid && !in_stall;
	assign item_valid = valid_s1;
	assign item       = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= in_data;
		end
	end

endmodule

/* src/prs_scan_core.sv */
// record parser state, configuration registers and per-byte result logic
// depends on prs_pkg
module prs_scan_core import prs_pkg::*; #(
	parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int UNIT_BYTES   = UNIT_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   item_valid,
	input  prs_in_t                item,
	input  logic                   advance,
	output logic                   res_valid,
	output prs_out_t               res
);

	localparam int SIZE_W = 8 + $clog2(UNIT_BYTES);
	localparam int DIFF_W = (SIZE_W > ADDR_WIDTH) ? SIZE_W : ADDR_WIDTH;
	localparam int EXT_W  = (DIFF_W > FREE_W) ? DIFF_W : FREE_W;

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_LEN    = 3'd1;
	localparam logic [2:0] PH_TYPE   = 3'd2;
	localparam logic [2:0] PH_LHI    = 3'd3;
	localparam logic [2:0] PH_LLO    = 3'd4;
	localparam logic [2:0] PH_SKIP   = 3'd5;
	localparam logic [2:0] PH_DATA   = 3'd6;
	localparam logic [2:0] PH_STOP   = 3'd7;

	logic                  fire;

	logic [7:0]            wanted_type_q;
	logic [LEN_W-1:0]      target_record_q;

	logic [ADDR_WIDTH-1:0] addr_q, addr_e, addr_n;
	logic [2:0]            phase_q, phase_e, phase_n;
	logic [7:0]            length_q, length_e, length_n;
	logic [7:0]            type_q, type_e, type_n;
	logic [ADDR_WIDTH-1:0] start_q, start_e, start_n;
	logic [LEN_W-1:0]      left_q, left_e, left_n;
	logic [7:0]            high_q, high_e, high_n;
	logic [LEN_W-1:0]      count_q, count_e, count_n;
	logic [SIZE_W-1:0]     size_q, size_e, size_n;
	logic [LEN_W-1:0]      cur_len_q, cur_len_e, cur_len_n;
	logic                  cur_long_q, cur_long_e, cur_long_n;
	logic                  cur_match_q, cur_match_e, cur_match_n;
	logic                  cur_target_q, cur_target_e, cur_target_n;

	logic [7:0]            b;
	logic                  open_match;
	logic [LEN_W-1:0]      open_count;
	logic                  open_target;
	logic [LEN_W-1:0]      word;
	logic [LEN_W-1:0]      left_dec;
	logic [DIFF_W-1:0]     size_ext, start_ext, diff;
	logic [EXT_W-1:0]      diff_ext;
	logic [FREE_W-1:0]     free_sat;
	logic                  ev_valid;
	logic [2:0]            ev_code;
	logic [7:0]            ev_data;
	logic [START_W-1:0]    ev_first;
	logic [FREE_W-1:0]     ev_free;

	assign fire = item_valid && advance;
	assign b    = item.pack_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_type_q   <= '0;
			target_record_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WANTED_TYPE: begin
					wanted_type_q <= cfg_data[7:0];
				end
				REG_TARGET_RECORD: begin
					target_record_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// restart clears the scan before the byte is handled
	always_comb begin
		if (item.start_req) begin
			addr_e       = '0;
			phase_e      = PH_HEADER;
			length_e     = '0;
			type_e       = '0;
			start_e      = '0;
			left_e       = '0;
			high_e       = '0;
			count_e      = '0;
			size_e       = '0;
			cur_len_e    = '0;
			cur_long_e   = 1'b0;
			cur_match_e  = 1'b0;
			cur_target_e = 1'b0;
		end else begin
			addr_e       = addr_q;
			phase_e      = phase_q;
			length_e     = length_q;
			type_e       = type_q;
			start_e      = start_q;
			left_e       = left_q;
			high_e       = high_q;
			count_e      = count_q;
			size_e       = size_q;
			cur_len_e    = cur_len_q;
			cur_long_e   = cur_long_q;
			cur_match_e  = cur_match_q;
			cur_target_e = cur_target_q;
		end
	end

	always_comb begin
		open_match  = ((phase_e == PH_TYPE) ? b : type_e) == wanted_type_q;
		open_count  = (open_match && count_e != '1) ? count_e + LEN_W'(1) : count_e;
		open_target = open_match && target_record_q != '0 && open_count == target_record_q;
		word        = {high_e, b};
		left_dec    = (left_e != '0) ? left_e - LEN_W'(1) : left_e;

		size_ext  = DIFF_W'(size_e);
		start_ext = DIFF_W'(start_e);
		diff      = (size_ext > start_ext) ? size_ext - start_ext : '0;
		diff_ext  = EXT_W'(diff);
		free_sat  = (diff_ext > EXT_W'({FREE_W{1'b1}})) ? '1 : diff_ext[FREE_W-1:0];
	end

	always_comb begin
		addr_n       = addr_e + ADDR_WIDTH'(1);
		phase_n      = phase_e;
		length_n     = length_e;
		type_n       = type_e;
		start_n      = start_e;
		left_n       = left_e;
		high_n       = high_e;
		count_n      = count_e;
		size_n       = size_e;
		cur_len_n    = cur_len_e;
		cur_long_n   = cur_long_e;
		cur_match_n  = cur_match_e;
		cur_target_n = cur_target_e;
		ev_valid     = 1'b0;
		ev_code      = EV_HEADER;
		ev_data      = '0;
		ev_first     = '0;
		ev_free      = '0;

		case (phase_e)
			PH_HEADER: begin
				if (addr_e == ADDR_WIDTH'(1)) begin
					size_n = SIZE_W'(b) * SIZE_W'(UNIT_BYTES);
				end
				if (addr_e >= ADDR_WIDTH'(HEADER_BYTES - 1)) begin
					phase_n = PH_LEN;
				end
			end
			PH_LEN: begin
				start_n  = addr_e;
				length_n = b;
				phase_n  = PH_TYPE;
			end
			PH_TYPE: begin
				type_n = b;
				if (length_e == '0) begin
					cur_len_n    = LEN_W'(length_e);
					cur_long_n   = 1'b0;
					cur_match_n  = 1'b0;
					cur_target_n = 1'b0;
					phase_n      = PH_STOP;
					ev_valid     = 1'b1;
					ev_code      = EV_ZERO_LEN;
				end else if (b == LONG_TYPE) begin
					phase_n = PH_LHI;
				end else if (b == END_MARK) begin
					cur_len_n    = LEN_W'(length_e);
					cur_long_n   = 1'b0;
					cur_match_n  = 1'b0;
					cur_target_n = 1'b0;
					phase_n      = PH_STOP;
					ev_valid     = 1'b1;
					if (length_e == END_MARK) begin
						ev_code  = EV_END;
						ev_first = START_W'(start_e);
						ev_free  = free_sat;
					end else begin
						ev_code = EV_BAD_END;
					end
				end else begin
					cur_len_n    = LEN_W'(length_e);
					cur_long_n   = 1'b0;
					cur_match_n  = open_match;
					count_n      = open_count;
					cur_target_n = open_target;
					left_n       = LEN_W'(length_e);
					phase_n      = PH_DATA;
					ev_valid     = 1'b1;
					ev_code      = EV_HEADER;
				end
			end
			PH_LHI: begin
				high_n  = b;
				phase_n = PH_LLO;
			end
			PH_LLO: begin
				left_n       = word;
				cur_len_n    = word;
				cur_long_n   = 1'b1;
				cur_match_n  = open_match;
				count_n      = open_count;
				cur_target_n = open_target;
				phase_n      = (word != '0) ? PH_SKIP : PH_LEN;
				ev_valid     = 1'b1;
				ev_code      = EV_HEADER;
			end
			PH_SKIP: begin
				left_n = left_dec;
				if (left_dec == '0) begin
					phase_n = PH_LEN;
				end
			end
			PH_DATA: begin
				left_n = left_dec;
				if (left_dec == '0) begin
					phase_n = PH_LEN;
				end
				ev_valid = 1'b1;
				ev_code  = EV_DATA;
				ev_data  = b;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res_valid          = ev_valid;
		res.event_res      = ev_code;
		res.record_start   = START_W'(start_n);
		res.rec_kind       = type_n;
		res.record_length  = cur_len_n;
		res.is_long        = cur_long_n;
		res.type_matches   = cur_match_n;
		res.match_count    = count_n;
		res.is_target      = cur_target_n;
		res.data_byte      = ev_data;
		res.free_addr      = ev_first;
		res.free_space     = ev_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			phase_q      <= PH_HEADER;
			length_q     <= '0;
			type_q       <= '0;
			start_q      <= '0;
			left_q       <= '0;
			high_q       <= '0;
			count_q      <= '0;
			size_q       <= '0;
			cur_len_q    <= '0;
			cur_long_q   <= 1'b0;
			cur_match_q  <= 1'b0;
			cur_target_q <= 1'b0;
		end else if (fire) begin
			addr_q       <= addr_n;
			phase_q      <= phase_n;
			length_q     <= length_n;
			type_q       <= type_n;
			start_q      <= start_n;
			left_q       <= left_n;
			high_q       <= high_n;
			count_q      <= count_n;
			size_q       <= size_n;
			cur_len_q    <= cur_len_n;
			cur_long_q   <= cur_long_n;
			cur_match_q  <= cur_match_n;
			cur_target_q <= cur_target_n;
		end
	end

endmodule

/* src/prs_out_stage.sv */
// result register of the pack record scanner
// depends on prs_pkg
module prs_out_stage import prs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	input  logic     res_valid,
	input  prs_out_t res,
	output logic     advance,
	output logic     out_valid,
	input  logic     out_stall,
	output prs_out_t out_data
);

	logic     valid_q;
	prs_out_t data_q;

	assign advance   = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= item_valid && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_valid && res_valid) begin
			data_q <= res;
		end
	end

endmodule

/* src/prs_checker.sv */
// port-level checks of the pack record scanner, bound to the top level
// depends on prs_pkg and pack_record_scanner_assert.svh
`include "pack_record_scanner_assert.svh"

module prs_checker import prs_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     out_valid,
	input logic     out_stall,
	input prs_out_t out_data
);

	logic held;
	logic stop_ev;
	logic no_flags;
	logic no_free;

	assign held     = out_valid && out_stall;
	assign stop_ev  = out_valid && (out_data.event_res == EV_END
		|| out_data.event_res == EV_ZERO_LEN || out_data.event_res == EV_BAD_END);
	assign no_flags = !out_data.is_long && !out_data.type_matches && !out_data.is_target;
	assign no_free  = out_data.free_addr == '0 && out_data.free_space == '0;

	`PRS_ASSERT_NEXT(a_out_hold, clk, arst_n, held, out_valid && $stable(out_data), "stalled word changed")
	`PRS_ASSERT_IMPLY(a_stop_flags, clk, arst_n, stop_ev, no_flags, "stop event carries record flags")
	`PRS_ASSERT_IMPLY(a_target, clk, arst_n, out_valid && out_data.is_target, out_data.type_matches && out_data.match_count != '0, "target without match")
	`PRS_ASSERT_IMPLY(a_free_only_end, clk, arst_n, out_valid && out_data.event_res != EV_END, no_free, "free space outside end event")
	`PRS_ASSERT_IMPLY(a_data_only, clk, arst_n, out_valid && out_data.event_res != EV_DATA, out_data.data_byte == '0, "data byte outside data event")

endmodule

bind pack_record_scanner prs_checker u_prs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

/* tb/tb.sv */
// testbench for pack_record_scanner: feeds pack images byte by byte and checks every event word
// against a scanner model kept in the bench; imports prs_pkg, needs only the scanner rtl
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import prs_pkg::*;

	typedef enum logic [2:0] {
		SCAN_HEADER,
		SCAN_LENGTH,
		SCAN_TYPE,
		SCAN_BLOCK_HI,
		SCAN_BLOCK_LO,
		SCAN_SKIP,
		SCAN_DATA,
		SCAN_STOPPED
	} scan_phase_t;

	typedef enum logic [1:0] {
		FLOW_FREE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE
	} stall_mode_t;

	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	prs_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	prs_out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_WANTED_TYPE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// scanner model state
	logic [ADDR_WIDTH_DEF-1:0] scan_addr;
	scan_phase_t scan_phase;
	logic [7:0] rec_len_byte;
	logic [7:0] rec_type;
	logic [START_W-1:0] hdr_addr;
	logic [LEN_W-1:0] rec_left;
	logic [7:0] block_hi;
	logic [LEN_W-1:0] wanted_seen;
	logic [7:0] pack_units;
	logic [LEN_W-1:0] cur_length;
	logic cur_long;
	logic cur_match;
	logic cur_target;
	logic [7:0] want_type = 8'h00;
	logic [LEN_W-1:0] target_index = '0;

	prs_in_t pack_feed[$];
	prs_out_t expected_events[$];

	int fed_bytes = 0;
	int mismatches = 0;
	int results_seen = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	int holds_done = 0;
	int mode_left = 0;
	int idle_cycles = 0;
	stall_mode_t stall_mode = FLOW_FREE;

	pack_record_scanner u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	task automatic clear_scan;
		scan_addr = '0;
		scan_phase = SCAN_HEADER;
		rec_len_byte = '0;
		rec_type = '0;
		hdr_addr = '0;
		rec_left = '0;
		block_hi = '0;
		wanted_seen = '0;
		pack_units = '0;
		cur_length = '0;
		cur_long = 1'b0;
		cur_match = 1'b0;
		cur_target = 1'b0;
	endtask

	task automatic close_scan;
		cur_length = {8'h00, rec_len_byte};
		cur_long = 1'b0;
		cur_match = 1'b0;
		cur_target = 1'b0;
		scan_phase = SCAN_STOPPED;
	endtask

	task automatic open_record(input logic [LEN_W-1:0] len, input logic long_rec);
		cur_length = len;
		cur_long = long_rec;
		cur_match = (rec_type == want_type);
		if (cur_match && wanted_seen != 16'hFFFF)
			wanted_seen++;
		cur_target = cur_match && target_index != 0 && wanted_seen == target_index;
	endtask

	function automatic prs_out_t event_word(input logic [2:0] ev, input logic [7:0] dbyte,
			input logic [START_W-1:0] ff, input logic [FREE_W-1:0] bf);
		prs_out_t w;
		w.event_res = ev;
		w.record_start = hdr_addr;
		w.rec_kind = rec_type;
		w.record_length = cur_length;
		w.is_long = cur_long;
		w.type_matches = cur_match;
		w.match_count = wanted_seen;
		w.is_target = cur_target;
		w.data_byte = dbyte;
		w.free_addr = ff;
		w.free_space = bf;
		return w;
	endfunction

	task automatic scan_pack_byte(input prs_in_t w);
		logic [ADDR_WIDTH_DEF-1:0] at;
		int unsigned pack_size;
		int unsigned room;
		if (w.start_req)
			clear_scan();
		at = scan_addr;
		case (scan_phase)
			SCAN_HEADER: begin
				if (at == 1)
					pack_units = w.pack_byte;
				if (at >= HEADER_BYTES_DEF - 1)
					scan_phase = SCAN_LENGTH;
			end
			SCAN_LENGTH: begin
				hdr_addr = at;
				rec_len_byte = w.pack_byte;
				scan_phase = SCAN_TYPE;
			end
			SCAN_TYPE: begin
				rec_type = w.pack_byte;
				if (rec_len_byte == 0) begin
					close_scan();
					expected_events.push_back(event_word(EV_ZERO_LEN, '0, '0, '0));
				end else if (w.pack_byte == LONG_TYPE) begin
					scan_phase = SCAN_BLOCK_HI;
				end else if (w.pack_byte == END_MARK) begin
					if (rec_len_byte == END_MARK) begin
						pack_size = pack_units * UNIT_BYTES_DEF;
						room = (pack_size > hdr_addr) ? pack_size - hdr_addr : 0;
						close_scan();
						expected_events.push_back(event_word(EV_END, '0, hdr_addr,
							room[FREE_W-1:0]));
					end else begin
						close_scan();
						expected_events.push_back(event_word(EV_BAD_END, '0, '0, '0));
					end
				end else begin
					open_record({8'h00, rec_len_byte}, 1'b0);
					rec_left = {8'h00, rec_len_byte};
					scan_phase = SCAN_DATA;
					expected_events.push_back(event_word(EV_HEADER, '0, '0, '0));
				end
			end
			SCAN_BLOCK_HI: begin
				block_hi = w.pack_byte;
				scan_phase = SCAN_BLOCK_LO;
			end
			SCAN_BLOCK_LO: begin
				rec_left = {block_hi, w.pack_byte};
				open_record(rec_left, 1'b1);
				scan_phase = (rec_left != 0) ? SCAN_SKIP : SCAN_LENGTH;
				expected_events.push_back(event_word(EV_HEADER, '0, '0, '0));
			end
			SCAN_SKIP: begin
				if (rec_left != 0)
					rec_left--;
				if (rec_left == 0)
					scan_phase = SCAN_LENGTH;
			end
			SCAN_DATA: begin
				if (rec_left != 0)
					rec_left--;
				if (rec_left == 0)
					scan_phase = SCAN_LENGTH;
				expected_events.push_back(event_word(EV_DATA, w.pack_byte, '0, '0));
			end
			default: begin
			end
		endcase
		scan_addr = at + 1'b1;
	endtask

	task automatic field_mismatch(input string field, input logic [FREE_W-1:0] want,
			input logic [FREE_W-1:0] got);
		mismatches++;
		$display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
	endtask

	task automatic check_word(input prs_out_t want, input prs_out_t got);
		if (got.event_res !== want.event_res)
			field_mismatch("event_res", FREE_W'(want.event_res), FREE_W'(got.event_res));
		if (got.record_start !== want.record_start)
			field_mismatch("record_start", FREE_W'(want.record_start),
				FREE_W'(got.record_start));
		if (got.rec_kind !== want.rec_kind)
			field_mismatch("rec_kind", FREE_W'(want.rec_kind), FREE_W'(got.rec_kind));
		if (got.record_length !== want.record_length)
			field_mismatch("record_length", FREE_W'(want.record_length),
				FREE_W'(got.record_length));
		if (got.is_long !== want.is_long)
			field_mismatch("is_long", FREE_W'(want.is_long), FREE_W'(got.is_long));
		if (got.type_matches !== want.type_matches)
			field_mismatch("type_matches", FREE_W'(want.type_matches),
				FREE_W'(got.type_matches));
		if (got.match_count !== want.match_count)
			field_mismatch("match_count", FREE_W'(want.match_count),
				FREE_W'(got.match_count));
		if (got.is_target !== want.is_target)
			field_mismatch("is_target", FREE_W'(want.is_target), FREE_W'(got.is_target));
		if (got.data_byte !== want.data_byte)
			field_mismatch("data_byte", FREE_W'(want.data_byte), FREE_W'(got.data_byte));
		if (got.free_addr !== want.free_addr)
			field_mismatch("free_addr", FREE_W'(want.free_addr), FREE_W'(got.free_addr));
		if (got.free_space !== want.free_space)
			field_mismatch("free_space", want.free_space, got.free_space);
	endtask

	task automatic feed_byte(input logic [7:0] b, input logic restart);
		prs_in_t w;
		w.pack_byte = b;
		w.start_req = restart;
		pack_feed.push_back(w);
		fed_bytes++;
	endtask

	task automatic feed_header(input logic [7:0] units);
		feed_byte(8'($urandom_range(0, 255)), 1'b1);
		feed_byte(units, 1'b0);
		repeat (HEADER_BYTES_DEF - 2)
			feed_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	function automatic logic [7:0] short_type_pick();
		logic [7:0] t;
		if ($urandom_range(0, 9) < 4)
			t = want_type;
		else
			t = 8'($urandom_range(0, 255));
		if (t == LONG_TYPE || t == END_MARK)
			t = t ^ 8'h01;
		return t;
	endfunction

	task automatic feed_records(input int count);
		int r;
		int len;
		int hi;
		int lo;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 255) : $urandom_range(1, 6);
				feed_byte(8'(len), 1'b0);
				feed_byte(short_type_pick(), 1'b0);
				repeat (len)
					feed_byte(8'($urandom_range(0, 255)), 1'b0);
			end else if (r < 88) begin
				hi = ($urandom_range(0, 29) == 0) ? 1 : 0;
				lo = hi ? $urandom_range(0, 255) : $urandom_range(0, 8);
				feed_byte(8'($urandom_range(1, 255)), 1'b0);
				feed_byte(LONG_TYPE, 1'b0);
				feed_byte(8'(hi), 1'b0);
				feed_byte(8'(lo), 1'b0);
				repeat (hi * 256 + lo)
					feed_byte(8'($urandom_range(0, 255)), 1'b0);
			end else begin
				feed_byte(8'($urandom_range(1, 6)), 1'b0);
				feed_byte(8'($urandom_range(0, 255)), 1'b0);
			end
		end
		r = $urandom_range(0, 9);
		if (r <= 5 || r == 9) begin
			feed_byte(END_MARK, 1'b0);
			feed_byte(END_MARK, 1'b0);
			if (r == 9)
				repeat ($urandom_range(1, 4))
					feed_byte(8'($urandom_range(0, 255)), 1'b0);
		end else if (r == 6) begin
			feed_byte(8'h00, 1'b0);
			feed_byte(8'($urandom_range(0, 255)), 1'b0);
		end else if (r == 7) begin
			feed_byte(8'($urandom_range(0, 254)), 1'b0);
			feed_byte(END_MARK, 1'b0);
		end
	endtask

	task automatic feed_phase(input int byte_goal);
		int goal;
		int r;
		goal = fed_bytes + byte_goal;
		// sometimes carry on the scan left over from the previous phase
		if ($urandom_range(0, 1))
			feed_records($urandom_range(1, 3));
		while (fed_bytes < goal) begin
			r = $urandom_range(0, 9);
			if (r == 0) begin
				repeat ($urandom_range(1, 12))
					feed_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 31) == 0));
			end else begin
				r = $urandom_range(0, 9);
				feed_header((r < 3) ? 8'h00 : (r < 7) ? 8'($urandom_range(1, 2)) :
					8'($urandom_range(0, 255)));
				feed_records($urandom_range(1, 8));
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_WANTED_TYPE)
			want_type = val[7:0];
		else
			target_index = val;
	endtask

	task automatic wait_idle;
		do
			@(posedge clk);
		while (pack_feed.size() != 0 || in_valid || expected_events.size() != 0);
		repeat (8)
			@(posedge clk);
	endtask

	// byte driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				scan_pack_byte(in_data);
				if (burst_left != 0)
					burst_left--;
			end
			if (!in_valid || !in_stall) begin
				if (burst_left == 0) begin
					case ($urandom_range(0, 9))
						0, 1: begin
							burst_left = $urandom_range(150, 300);
							gap_left = 0;
						end
						2: begin
							burst_left = $urandom_range(1, 20);
							gap_left = $urandom_range(15, 50);
						end
						default: begin
							burst_left = $urandom_range(1, 20);
							gap_left = $urandom_range(0, 4);
						end
					endcase
				end
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pack_feed.size() != 0) begin
					in_valid <= 1'b1;
					in_data <= pack_feed.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result stall pattern, with two long hold-offs
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (holds_done < 2 && results_seen >= 300 * (holds_done + 1)) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end else begin
					mode_left--;
				end
				case (stall_mode)
					FLOW_FREE: out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_events.size() == 0) begin
				mismatches++;
				$display("%0t ns: word expected none, got %p", $time, out_data);
			end else begin
				check_word(expected_events.pop_front(), out_data);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		clear_scan();
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// long pack: short record, zero and nonzero long blocks, end marker, byte after end
		feed_header(8'hFF);
		feed_byte(8'd2, 1'b0);
		feed_byte(8'h00, 1'b0);
		feed_byte(8'h00, 1'b0);
		feed_byte(8'hFF, 1'b0);
		feed_byte(8'd1, 1'b0);
		feed_byte(LONG_TYPE, 1'b0);
		feed_byte(8'h00, 1'b0);
		feed_byte(8'h00, 1'b0);
		feed_byte(8'd3, 1'b0);
		feed_byte(LONG_TYPE, 1'b0);
		feed_byte(8'h00, 1'b0);
		feed_byte(8'd2, 1'b0);
		feed_byte(8'hA5, 1'b0);
		feed_byte(8'h5A, 1'b0);
		feed_byte(END_MARK, 1'b0);
		feed_byte(END_MARK, 1'b0);
		feed_byte(8'h33, 1'b0);
		// restart in the middle of a record
		feed_header(8'h01);
		feed_byte(8'd4, 1'b0);
		feed_byte(8'h11, 1'b0);
		feed_byte(8'h22, 1'b0);
		// zero length
		feed_header(8'h00);
		feed_byte(8'h00, 1'b0);
		feed_byte(8'h07, 1'b0);
		// bad end marker
		feed_header(8'h01);
		feed_byte(8'd5, 1'b0);
		feed_byte(END_MARK, 1'b0);
		wait_idle();

		write_reg(REG_WANTED_TYPE, {8'($urandom_range(0, 255)), LONG_TYPE});
		write_reg(REG_TARGET_RECORD, 16'd2);
		feed_phase(440);
		wait_idle();

		write_reg(REG_WANTED_TYPE, {8'($urandom_range(0, 255)), END_MARK});
		write_reg(REG_TARGET_RECORD, 16'd0);
		feed_phase(440);
		wait_idle();

		write_reg(REG_WANTED_TYPE, 16'($urandom_range(0, 65535)));
		write_reg(REG_TARGET_RECORD, 16'($urandom_range(1, 6)));
		feed_phase(440);
		wait_idle();

		write_reg(REG_WANTED_TYPE, 16'h0000);
		write_reg(REG_TARGET_RECORD, 16'd1);
		feed_phase(440);
		wait_idle();

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
